// File: design/etrb_pkg.sv
package etrb_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;

  localparam int CNT_W    = 7;
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 20;
  localparam int TOTAL_W  = 32;
  localparam int ID_W     = 16;
  localparam int VALUE_W  = 64;
  localparam int DUR_W    = 32;
  localparam int TIME_W   = 64;
  localparam int AVAIL_W  = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 20'd10000;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_SYSCALL = 2'd0,
    KIND_PROC    = 2'd1,
    KIND_MEM     = 2'd2,
    KIND_IO      = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    pid;
    logic [ID_W-1:0]    code;
    logic [VALUE_W-1:0] value;
    logic [DUR_W-1:0]   duration;
    logic [TIME_W-1:0]  stamp;
  } sample_t;

  typedef struct packed {
    cmd_t             cmd;
    sample_t          sample;
    logic [CNT_W-1:0] limit;
  } cmd_item_t;

endpackage

// File: design/etrb_ifs.sv
interface etrb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  event_kind;
  logic [15:0] pid;
  logic [15:0] code;
  logic [63:0] value;
  logic [31:0] duration;
  logic [6:0]  drain_max;

  modport source (output valid, func, event_kind, pid, code, value, duration, drain_max,
                  input ready);
  modport sink (input valid, func, event_kind, pid, code, value, duration, drain_max,
                output ready);
endinterface

interface etrb_out_if;
  logic        valid;
  logic        ready;
  logic        has_sample;
  logic        last;
  logic [1:0]  out_kind;
  logic [15:0] out_pid;
  logic [15:0] out_code;
  logic [63:0] out_value;
  logic [31:0] out_duration;
  logic [63:0] out_time;
  logic [7:0]  available_count;
  logic [31:0] total_count;

  modport source (output valid, has_sample, last, out_kind, out_pid, out_code, out_value,
                  out_duration, out_time, available_count, total_count,
                  input ready);
  modport sink (input valid, has_sample, last, out_kind, out_pid, out_code, out_value,
                out_duration, out_time, available_count, total_count,
                output ready);
endinterface

interface etrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] tick_period_us;

  modport source (output valid, tick_period_us, input ready);
  modport sink (input valid, tick_period_us, output ready);
endinterface

// File: design/etrb_front.sv
module etrb_front #(
  parameter int MAX_BURST = etrb_pkg::MAX_BURST_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  etrb_in_if.sink              in_ch,
  etrb_cfg_if.sink             cfg_ch,
  input  logic                 q_full,
  output logic                 push,
  output etrb_pkg::cmd_item_t  push_item
);
  import etrb_pkg::*;

  logic [PERIOD_W-1:0]        period_r;
  logic [TICK_W-1:0]          tick_r;
  logic [TICK_W-1:0]          tick_nxt;
  logic [TICK_W+PERIOD_W-1:0] prod;
  logic                       accept;
  sample_t                    smp;
  logic [CNT_W-1:0]           limit;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign prod         = tick_r * period_r;

  always_comb begin
    smp.kind     = kind_t'(in_ch.event_kind);
    smp.pid      = in_ch.pid;
    smp.code     = in_ch.code;
    smp.value    = in_ch.value;
    smp.duration = in_ch.duration;
    smp.stamp    = TIME_W'(prod);
    case (smp.kind)
      KIND_SYSCALL: smp.value = '0;
      KIND_PROC: begin
        smp.value    = '0;
        smp.duration = '0;
      end
      KIND_MEM:     smp.duration = '0;
      KIND_IO:      smp.code = '0;
      default:      smp.code = in_ch.code;
    endcase

    limit = (in_ch.drain_max > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : in_ch.drain_max;

    push             = 1'b0;
    tick_nxt         = tick_r;
    push_item.cmd    = CMD_RECORD;
    push_item.sample = smp;
    push_item.limit  = limit;
    case (func_t'(in_ch.func))
      FUNC_RECORD: push = accept;
      FUNC_TICK: begin
        if (accept) tick_nxt = tick_r + 1'b1;
      end
      FUNC_READ: begin
        push          = accept;
        push_item.cmd = CMD_READ;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= TICK_PERIOD_RST;
      tick_r   <= '0;
    end else begin
      tick_r <= tick_nxt;
      if (cfg_ch.valid && cfg_ch.ready) period_r <= cfg_ch.tick_period_us;
    end
  end

endmodule

// File: design/etrb_queue.sv
module etrb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  etrb_pkg::cmd_item_t  push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 nonempty,
  output etrb_pkg::cmd_item_t  head
);
  import etrb_pkg::*;

  cmd_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/etrb_back.sv
module etrb_back #(
  parameter int DEPTH = etrb_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  etrb_pkg::cmd_item_t  head,
  output logic                 pop,
  etrb_out_if.source           out_ch
);
  import etrb_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AVW = (AW + 1 > AVAIL_W) ? AW + 1 : AVAIL_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_V  = (AW+1)'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DATA} state_t;

  state_t              state_r;
  logic [AW-1:0]       wr_r;
  logic [AW-1:0]       rd_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    limit_r;
  logic                last_r;
  logic [AVAIL_W-1:0]  avail_r;
  sample_t             mem [DEPTH];
  sample_t             rdata_r;

  logic                out_valid_r;
  logic                has_r;
  logic                olast_r;
  sample_t             osmp_r;
  logic [AVAIL_W-1:0]  oavail_r;
  logic [TOTAL_W-1:0]  ototal_r;

  logic                out_free;
  logic                out_load;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       wr_inc;
  logic [AW-1:0]       rd_inc;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AVAIL_W-1:0] avail_of(input logic [AW-1:0] w,
                                                  input logic [AW-1:0] r);
    logic [AW:0]    d;
    logic [AVW-1:0] e;
    if (w >= r) d = {1'b0, w} - {1'b0, r};
    else        d = {1'b0, w} + DEPTH_V - {1'b0, r};
    e = AVW'(d);
    return e[AVAIL_W-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == S_IDLE) && q_valid;
  assign mem_we   = pop && (head.cmd == CMD_RECORD);
  assign mem_re   = (state_r == S_ISSUE) && (n_r < limit_r) && (rd_r != wr_r);
  assign wr_inc   = idx_inc(wr_r);
  assign rd_inc   = idx_inc(rd_r);
  assign out_load = out_free && (((state_r == S_ISSUE) && !mem_re && (n_r == '0)) ||
                                 (state_r == S_DATA));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_r] <= head.sample;
    if (mem_re) rdata_r <= mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      total_r     <= '0;
      n_r         <= '0;
      limit_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (head.cmd == CMD_RECORD) begin
              wr_r    <= wr_inc;
              total_r <= total_r + 1'b1;
              if (wr_inc == rd_r) rd_r <= rd_inc;
            end else begin
              limit_r <= head.limit;
              n_r     <= '0;
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (mem_re) begin
            rd_r    <= rd_inc;
            n_r     <= n_r + 1'b1;
            last_r  <= (n_r + 1'b1 == limit_r) || (rd_inc == wr_r);
            avail_r <= avail_of(wr_r, rd_inc);
            state_r <= S_DATA;
          end else if (n_r == '0) begin
            if (out_free) begin
              has_r       <= 1'b0;
              olast_r     <= 1'b1;
              osmp_r      <= '0;
              oavail_r    <= avail_of(wr_r, rd_r);
              ototal_r    <= total_r;
              state_r     <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DATA: begin
          if (out_free) begin
            has_r       <= 1'b1;
            olast_r     <= last_r;
            osmp_r      <= rdata_r;
            oavail_r    <= avail_r;
            ototal_r    <= total_r;
            state_r     <= last_r ? S_IDLE : S_ISSUE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.has_sample      = has_r;
  assign out_ch.last            = olast_r;
  assign out_ch.out_kind        = osmp_r.kind;
  assign out_ch.out_pid         = osmp_r.pid;
  assign out_ch.out_code        = osmp_r.code;
  assign out_ch.out_value       = osmp_r.value;
  assign out_ch.out_duration    = osmp_r.duration;
  assign out_ch.out_time        = osmp_r.stamp;
  assign out_ch.available_count = oavail_r;
  assign out_ch.total_count     = ototal_r;

endmodule

// File: design/event_trace_ring_buffer.sv
// Overwriting circular trace buffer of DEPTH slots (DEPTH-1 usable). The front end takes
// one beat per cycle while its queue has room: ticks are absorbed there, while records
// (stamped with tick count times the period, 32x20 multiply) and reads go into a four-entry
// command queue, so in_ready drops only when that queue is full. The back end stores a
// record as it pops it; a read leaves idle for the issue state, and each drained sample
// passes the registered store read and then the output register. The sample store is not
// cleared at reset and needs no start-up pass.
module event_trace_ring_buffer #(
  parameter int DEPTH     = etrb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = etrb_pkg::MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  etrb_in_if.sink     in_ch,
  etrb_out_if.source  out_ch,
  etrb_cfg_if.sink    cfg_ch
);
  import etrb_pkg::*;

  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  cmd_item_t push_item;
  cmd_item_t head;

  etrb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  etrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_valid),
    .head      (head)
  );

  etrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: sim/etrb_checker.sv
module etrb_checker (
  input  logic        clk,
  input  logic        rst_n,
  etrb_in_if          in_ch,
  etrb_out_if         out_ch,
  etrb_cfg_if         cfg_ch,
  output int unsigned errors,
  output int unsigned pending
);
  import etrb_pkg::*;

  typedef struct {
    logic                has_sample;
    logic                last;
    sample_t             smp;
    logic [AVAIL_W-1:0]  avail;
    logic [TOTAL_W-1:0]  total;
  } drained_t;

  logic [PERIOD_W-1:0] period;
  logic [TICK_W-1:0]   ticks;
  logic [TOTAL_W-1:0]  total;
  logic [AVAIL_W-1:0]  wr_ptr;
  logic [AVAIL_W-1:0]  rd_ptr;
  sample_t             ring [DEPTH_DEF];
  drained_t            drain_due [$];

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void compare_beat();
    drained_t want;
    if (drain_due.size() == 0) begin
      $error("result beat with no read outstanding");
      errors++;
      return;
    end
    want = drain_due.pop_front();
    check_field("has_sample", want.has_sample, out_ch.has_sample);
    check_field("last", want.last, out_ch.last);
    check_field("out_kind", want.smp.kind, out_ch.out_kind);
    check_field("out_pid", want.smp.pid, out_ch.out_pid);
    check_field("out_code", want.smp.code, out_ch.out_code);
    check_field("out_value", want.smp.value, out_ch.out_value);
    check_field("out_duration", want.smp.duration, out_ch.out_duration);
    check_field("out_time", want.smp.stamp, out_ch.out_time);
    check_field("available_count", want.avail, out_ch.available_count);
    check_field("total_count", want.total, out_ch.total_count);
  endfunction

  function automatic void store_event();
    sample_t s;
    s.kind     = kind_t'(in_ch.event_kind);
    s.pid      = in_ch.pid;
    s.code     = in_ch.code;
    s.value    = in_ch.value;
    s.duration = in_ch.duration;
    case (s.kind)
      KIND_SYSCALL: s.value = '0;
      KIND_PROC: begin
        s.value    = '0;
        s.duration = '0;
      end
      KIND_MEM: s.duration = '0;
      KIND_IO:  s.code = '0;
      default: ;
    endcase
    s.stamp = 64'(ticks) * 64'(period);
    // full ring drops the oldest unread entry
    if (AVAIL_W'(wr_ptr + 1'b1) == rd_ptr) rd_ptr = rd_ptr + 1'b1;
    ring[wr_ptr] = s;
    wr_ptr = wr_ptr + 1'b1;
    total  = total + 1'b1;
  endfunction

  function automatic void drain_ring();
    int unsigned lim;
    int unsigned n;
    drained_t    b;
    lim = (in_ch.drain_max > MAX_BURST_DEF) ? MAX_BURST_DEF : in_ch.drain_max;
    n = 0;
    while (n < lim && rd_ptr != wr_ptr) begin
      b.has_sample = 1'b1;
      b.smp        = ring[rd_ptr];
      rd_ptr       = rd_ptr + 1'b1;
      n++;
      b.last  = (n == lim) || (rd_ptr == wr_ptr);
      b.avail = wr_ptr - rd_ptr;
      b.total = total;
      drain_due.push_back(b);
    end
    if (n == 0) begin
      b.has_sample = 1'b0;
      b.last       = 1'b1;
      b.smp        = '0;
      b.avail      = wr_ptr - rd_ptr;
      b.total      = total;
      drain_due.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      period = TICK_PERIOD_RST;
      ticks  = '0;
      total  = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      errors = 0;
      drain_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) compare_beat();
      if (cfg_ch.valid && cfg_ch.ready) period = cfg_ch.tick_period_us;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          FUNC_RECORD: store_event();
          FUNC_TICK:   ticks = ticks + 1'b1;
          FUNC_READ:   drain_ring();
          default: ;
        endcase
      end
    end
    pending <= drain_due.size();
  end

endmodule

// File: sim/event_trace_ring_buffer_tb.sv
module event_trace_ring_buffer_tb;
  import etrb_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 5_000_000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         func;
    kind_t              kind;
    logic [ID_W-1:0]    pid;
    logic [ID_W-1:0]    code;
    logic [VALUE_W-1:0] value;
    logic [DUR_W-1:0]   dur;
    logic [CNT_W-1:0]   maxc;
  } trace_cmd_t;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned beats_pending;
  int unsigned cycle_count;
  int unsigned holds_asked = 0;
  bit          tx_calm = 1'b0;

  etrb_in_if  in_ch ();
  etrb_out_if out_ch ();
  etrb_cfg_if cfg_ch ();

  event_trace_ring_buffer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  etrb_checker trace_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (fail_count),
    .pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 24) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CNT_W-1:0] burst_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CNT_W'($urandom_range(9, 64));
    if (r == 2) return CNT_W'($urandom_range(65, 127));
    return CNT_W'($urandom_range(1, 8));
  endfunction

  function automatic trace_cmd_t mk(logic [1:0] func, kind_t kind, logic [15:0] pid,
                                    logic [15:0] code, logic [63:0] value,
                                    logic [31:0] dur, logic [6:0] maxc);
    trace_cmd_t c;
    c.func  = func;
    c.kind  = kind;
    c.pid   = pid;
    c.code  = code;
    c.value = value;
    c.dur   = dur;
    c.maxc  = maxc;
    return c;
  endfunction

  function automatic trace_cmd_t any_cmd(logic [1:0] func);
    return mk(func, kind_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
              {$urandom, $urandom}, $urandom, burst_len());
  endfunction

  function automatic trace_cmd_t mixed_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return any_cmd(FUNC_RECORD);
    if (r < 70) return any_cmd(FUNC_TICK);
    if (r < 96) return any_cmd(FUNC_READ);
    return any_cmd(FUNC_UNUSED);
  endfunction

  task automatic push_cmd(input trace_cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
    gap = (!tx_calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= c.func;
    in_ch.event_kind <= c.kind;
    in_ch.pid        <= c.pid;
    in_ch.code       <= c.code;
    in_ch.value      <= c.value;
    in_ch.duration   <= c.dur;
    in_ch.drain_max  <= c.maxc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] us);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.tick_period_us <= us;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [63:0] ones;
    ones = '1;
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd5));
    push_cmd(mk(FUNC_RECORD, KIND_SYSCALL, 16'hFFFF, 16'hFFFF, ones, '1, 7'd0));
    push_cmd(mk(FUNC_TICK, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd0));
    push_cmd(mk(FUNC_RECORD, KIND_PROC, 16'h0, 16'hFFFF, ones, '1, 7'd0));
    push_cmd(mk(FUNC_TICK, KIND_IO, 16'hFFFF, 16'hFFFF, ones, '1, '1));
    push_cmd(mk(FUNC_RECORD, KIND_MEM, 16'h1234, 16'h0, ones, '1, 7'd0));
    push_cmd(mk(FUNC_RECORD, KIND_MEM, 16'h1, 16'h1, 64'h0, '1, 7'd0));
    push_cmd(mk(FUNC_RECORD, KIND_IO, 16'hABCD, 16'hFFFF, ones, '1, 7'd0));
    // zero burst on a non-empty ring
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd0));
    push_cmd(mk(FUNC_UNUSED, KIND_IO, 16'hFFFF, 16'hFFFF, ones, '1, '1));
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd2));
    push_cmd(mk(FUNC_READ, KIND_IO, 16'hFFFF, 16'hFFFF, ones, '1, 7'd127));
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd1));
    push_cmd(mk(FUNC_RECORD, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd0));
    push_cmd(mk(FUNC_TICK, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd0));
    push_cmd(mk(FUNC_RECORD, KIND_IO, 16'h0, 16'h0, 64'h0, 32'h0, 7'd0));
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd64));
  endtask

  // more records than slots, so the oldest entries get overwritten
  task automatic overrun_ring();
    push_cmd(any_cmd(FUNC_TICK));
    for (int i = 0; i < 262; i++) begin
      push_cmd(any_cmd((i % 50 == 49) ? FUNC_TICK : FUNC_RECORD));
    end
    repeat (4) push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd64));
    push_cmd(mk(FUNC_READ, KIND_SYSCALL, 16'h0, 16'h0, 64'h0, 32'h0, 7'd127));
  endtask

  task automatic run_random(input int unsigned n);
    trace_cmd_t  c;
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      c = mixed_cmd();
      push_cmd(c);
      if (c.func != FUNC_UNUSED) sent++;
    end
  endtask

  initial begin
    int unsigned holds_served;
    int unsigned stall;
    bit          rx_calm;
    holds_served = 0;
    stall        = 0;
    rx_calm      = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          stall--;
        end else begin
          out_ch.ready <= 1'b1;
          if (!rx_calm && $urandom_range(0, 3) == 0) stall = idle_len();
        end
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_RECORD;
    in_ch.event_kind      = KIND_SYSCALL;
    in_ch.pid             = '0;
    in_ch.code            = '0;
    in_ch.value           = '0;
    in_ch.duration        = '0;
    in_ch.drain_max       = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.tick_period_us = TICK_PERIOD_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    settle();
    write_period(20'd1);
    overrun_ring();
    settle();
    write_period(20'd1000000);
    holds_asked <= holds_asked + 1;
    // reads pile up behind the held receiver until the input stalls
    repeat (8) push_cmd(any_cmd(FUNC_READ));
    run_random(10);
    settle();
    write_period(PERIOD_W'($urandom_range(1, 1000000)));
    run_random(8);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/etrb_pkg.sv
design/etrb_ifs.sv
design/etrb_front.sv
design/etrb_queue.sv
design/etrb_back.sv
design/event_trace_ring_buffer.sv
sim/etrb_checker.sv
sim/event_trace_ring_buffer_tb.sv
